// ----- hdl/cpl3d_pkg.sv -----
`default_nettype none
package cpl3d_pkg;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int EW = 16;

	localparam int DW = CW + 1;
	localparam int MW = 2 * DW;
	localparam int DOTW = MW + 2;
	localparam int HW = DOTW / 2;
	localparam int PRW = 2 * DOTW;
	localparam int DENW = PRW + 1;
	localparam int NUMW = DENW + FB;
	localparam int QB = CW - 1;
	localparam int RW = NUMW + QB;
	localparam int NPW = CW + DW;
	localparam int NEARW = NPW - FB + 1;

	typedef logic [EW-1:0] eps_t;
	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [MW-1:0] mprod_t;
	typedef logic signed [DOTW-1:0] dot_t;
	typedef logic signed [PRW-1:0] prod_t;
	typedef logic signed [DENW-1:0] den_t;
	typedef logic signed [NUMW-1:0] num_t;
	typedef logic signed [NPW-1:0] nprod_t;

	localparam eps_t EPS_RST = EW'(7);
	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DEG_B = 2'd1,
		ST_DEG_A = 2'd2,
		ST_PAR   = 2'd3
	} status_t;

	typedef struct packed {
		coord_t [2:0] p1;
		coord_t [2:0] p3;
		diff_t [2:0] d21;
		diff_t [2:0] d43;
	} geom_t;

	typedef struct packed {
		status_t st;
		geom_t g;
		dot_t d1343;
		dot_t d4321;
		dot_t d4343;
	} side_a_t;

	typedef struct packed {
		status_t st;
		geom_t g;
		coord_t mua;
		coord_t [2:0] near_a;
	} side_b_t;

	localparam int SIDE_W = ($bits(side_a_t) > $bits(side_b_t)) ?
		$bits(side_a_t) : $bits(side_b_t);
	typedef logic [SIDE_W-1:0] side_t;

	function automatic logic [DW-1:0] diff_mag(input diff_t d);
		return d[DW-1] ? DW'(-d) : DW'(d);
	endfunction

	function automatic coord_t sat_near(input logic signed [NEARW-1:0] v);
		logic [NEARW-CW:0] top;
		top = v[NEARW-1:CW-1];
		if (top == '0 || top == '1) begin
			return v[CW-1:0];
		end
		return v[NEARW-1] ? CMIN : CMAX;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/cpl3d_in_if.sv -----
`default_nettype none
interface cpl3d_in_if;
	import cpl3d_pkg::*;
	logic valid;
	logic ready;
	coord_t a_start_x, a_start_y, a_start_z;
	coord_t a_end_x, a_end_y, a_end_z;
	coord_t b_start_x, b_start_y, b_start_z;
	coord_t b_end_x, b_end_y, b_end_z;

	modport source(output valid, output a_start_x, a_start_y, a_start_z,
		a_end_x, a_end_y, a_end_z, b_start_x, b_start_y, b_start_z,
		b_end_x, b_end_y, b_end_z, input ready);
	modport sink(input valid, input a_start_x, a_start_y, a_start_z,
		a_end_x, a_end_y, a_end_z, b_start_x, b_start_y, b_start_z,
		b_end_x, b_end_y, b_end_z, output ready);
endinterface
`default_nettype wire

// ----- hdl/cpl3d_out_if.sv -----
`default_nettype none
interface cpl3d_out_if;
	import cpl3d_pkg::*;
	logic valid;
	logic ready;
	status_t status;
	coord_t near_a_x, near_a_y, near_a_z;
	coord_t near_b_x, near_b_y, near_b_z;
	coord_t param_a, param_b;

	modport source(output valid, output status, near_a_x, near_a_y, near_a_z,
		near_b_x, near_b_y, near_b_z, param_a, param_b, input ready);
	modport sink(input valid, input status, near_a_x, near_a_y, near_a_z,
		near_b_x, near_b_y, near_b_z, param_a, param_b, output ready);
endinterface
`default_nettype wire

// ----- hdl/cpl3d_div.sv -----
`default_nettype none
module cpl3d_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cpl3d_pkg::num_t   num,
	input  cpl3d_pkg::den_t   den,
	input  cpl3d_pkg::side_t  side_in,
	output logic              out_valid,
	input  logic              out_ready,
	output cpl3d_pkg::coord_t quo,
	output cpl3d_pkg::side_t  side_out
);
	import cpl3d_pkg::*;

	// stage 0 magnitudes, stage 1 overflow check, one quotient bit per stage, last stage sign
	localparam int NS = QB + 3;

	logic [NS-1:0]   v_s;
	logic [NS-1:0]   en;
	logic [RW-1:0]   r_s   [NS-1];
	logic [DENW-1:0] d_s   [NS-1];
	logic [QB-1:0]   q_s   [NS-1];
	logic            neg_s [NS-1];
	logic            sat_s [NS-1];
	side_t           side_s [NS];
	coord_t          quo_s;
	logic [RW-1:0]   n_ext;

	always_comb begin
		en[NS-1] = ~v_s[NS-1] | out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = ~v_s[k] | en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[NS-1];
	assign quo       = quo_s;
	assign side_out  = side_s[NS-1];
	assign n_ext     = {{(RW-NUMW){num[NUMW-1]}}, num};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) begin
				v_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [RW-1:0] t;
		if (en[0]) begin
			r_s[0]    <= num[NUMW-1] ? -n_ext : n_ext;
			d_s[0]    <= den[DENW-1] ? DENW'(-den) : DENW'(den);
			neg_s[0]  <= num[NUMW-1] ^ den[DENW-1];
			sat_s[0]  <= 1'b0;
			q_s[0]    <= '0;
			side_s[0] <= side_in;
		end
		if (en[1]) begin
			r_s[1]    <= r_s[0];
			d_s[1]    <= d_s[0];
			neg_s[1]  <= neg_s[0];
			sat_s[1]  <= r_s[0] >= (RW'(d_s[0]) << QB);
			q_s[1]    <= '0;
			side_s[1] <= side_s[0];
		end
		for (int k = 2; k < NS - 1; k++) begin
			t = RW'(d_s[k-1]) << (NS - 2 - k);
			if (en[k]) begin
				d_s[k]    <= d_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				sat_s[k]  <= sat_s[k-1];
				side_s[k] <= side_s[k-1];
				if (r_s[k-1] >= t) begin
					r_s[k] <= r_s[k-1] - t;
					q_s[k] <= q_s[k-1] | (QB'(1) << (NS - 2 - k));
				end else begin
					r_s[k] <= r_s[k-1];
					q_s[k] <= q_s[k-1];
				end
			end
		end
		if (en[NS-1]) begin
			side_s[NS-1] <= side_s[NS-2];
			if (sat_s[NS-2]) begin
				quo_s <= neg_s[NS-2] ? CMIN : CMAX;
			end else begin
				quo_s <= neg_s[NS-2] ? -coord_t'({1'b0, q_s[NS-2]}) :
					coord_t'({1'b0, q_s[NS-2]});
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/closest_points_two_lines_3d_top.sv -----
`default_nettype none
// Closest points between two 3D lines in signed Q16.16. Takes one line pair per
// cycle when the output side keeps up; the depth comes from two 34-stage
// restoring dividers (mua, then mub) plus eleven arithmetic stages. Stalls on the
// output hold every stage; empty stages still fill. eps_threshold may be written
// only while the pipeline is empty.
module closest_points_two_lines_3d_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  cpl3d_pkg::eps_t     cfg_wr_data,
	cpl3d_in_if.sink            in_ch,
	cpl3d_out_if.source         out_ch
);
	import cpl3d_pkg::*;

	eps_t eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RST;
		end else if (cfg_wr_en) begin
			eps_q <= cfg_wr_data;
		end
	end

	logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en10, en11;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic diva_in_ready, diva_valid, divb_in_ready, divb_valid;

	// stage 1: differences, degenerate tests
	coord_t ias [3], iae [3], ibs [3], ibe [3];
	diff_t  d13c [3], d43c [3], d21c [3];
	logic   degb_c, dega_c;

	assign ias[0] = in_ch.a_start_x;
	assign ias[1] = in_ch.a_start_y;
	assign ias[2] = in_ch.a_start_z;
	assign iae[0] = in_ch.a_end_x;
	assign iae[1] = in_ch.a_end_y;
	assign iae[2] = in_ch.a_end_z;
	assign ibs[0] = in_ch.b_start_x;
	assign ibs[1] = in_ch.b_start_y;
	assign ibs[2] = in_ch.b_start_z;
	assign ibe[0] = in_ch.b_end_x;
	assign ibe[1] = in_ch.b_end_y;
	assign ibe[2] = in_ch.b_end_z;

	always_comb begin
		degb_c = 1'b1;
		dega_c = 1'b1;
		for (int k = 0; k < 3; k++) begin
			d13c[k] = DW'(ias[k]) - DW'(ibs[k]);
			d43c[k] = DW'(ibe[k]) - DW'(ibs[k]);
			d21c[k] = DW'(iae[k]) - DW'(ias[k]);
			degb_c &= diff_mag(d43c[k]) < DW'(eps_q);
			dega_c &= diff_mag(d21c[k]) < DW'(eps_q);
		end
	end

	assign in_ch.ready = en1;

	geom_t  g_s1, g_s2, g_s3, g_s4, g_s5, g_s6, g_s7;
	diff_t  d13_s1 [3];
	logic   degb_s1, dega_s1, degb_s2, dega_s2, degb_s3, dega_s3;
	logic   degb_s4, dega_s4, degb_s5, dega_s5, degb_s6, dega_s6;
	mprod_t m1343_s2 [3], m4321_s2 [3], m1321_s2 [3], m4343_s2 [3], m2121_s2 [3];
	dot_t   d1343_s3, d4321_s3, d1321_s3, d4343_s3, d2121_s3;
	dot_t   d1343_s4, d4321_s4, d4343_s4;
	dot_t   d1343_s5, d4321_s5, d4343_s5;
	dot_t   d1343_s6, d4321_s6, d4343_s6;
	dot_t   d1343_s7, d4321_s7, d4343_s7;
	dot_t   opa [4], opb [4];
	logic signed [2*HW-1:0] hh_s4 [4];
	logic signed [2*HW:0]   hl_s4 [4], lh_s4 [4];
	logic signed [2*HW+1:0] ll_s4 [4];
	prod_t  pr_s5 [4];
	den_t   denom_s6, numer_s6, denom_s7, numer_s7;
	logic   par_c;
	status_t st_c;
	status_t st_s7;

	assign en11 = ~v_s11 | out_ch.ready;
	assign en10 = ~v_s10 | en11;
	assign en9  = ~v_s9 | divb_in_ready;
	assign en8  = ~v_s8 | en9;
	assign en7  = ~v_s7 | diva_in_ready;
	assign en6  = ~v_s6 | en7;
	assign en5  = ~v_s5 | en6;
	assign en4  = ~v_s4 | en5;
	assign en3  = ~v_s3 | en4;
	assign en2  = ~v_s2 | en3;
	assign en1  = ~v_s1 | en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
		end else begin
			if (en1)  v_s1  <= in_ch.valid;
			if (en2)  v_s2  <= v_s1;
			if (en3)  v_s3  <= v_s2;
			if (en4)  v_s4  <= v_s3;
			if (en5)  v_s5  <= v_s4;
			if (en6)  v_s6  <= v_s5;
			if (en7)  v_s7  <= v_s6;
			if (en8)  v_s8  <= diva_valid;
			if (en9)  v_s9  <= v_s8;
			if (en10) v_s10 <= divb_valid;
			if (en11) v_s11 <= v_s10;
		end
	end

	assign opa[0] = d2121_s3;
	assign opb[0] = d4343_s3;
	assign opa[1] = d4321_s3;
	assign opb[1] = d4321_s3;
	assign opa[2] = d1343_s3;
	assign opb[2] = d4321_s3;
	assign opa[3] = d1321_s3;
	assign opb[3] = d4343_s3;

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int k = 0; k < 3; k++) begin
				g_s1.p1[k]  <= ias[k];
				g_s1.p3[k]  <= ibs[k];
				g_s1.d21[k] <= d21c[k];
				g_s1.d43[k] <= d43c[k];
				d13_s1[k]   <= d13c[k];
			end
			degb_s1 <= degb_c;
			dega_s1 <= dega_c;
		end
		if (en2) begin
			for (int k = 0; k < 3; k++) begin
				m1343_s2[k] <= d13_s1[k] * g_s1.d43[k];
				m4321_s2[k] <= g_s1.d43[k] * g_s1.d21[k];
				m1321_s2[k] <= d13_s1[k] * g_s1.d21[k];
				m4343_s2[k] <= g_s1.d43[k] * g_s1.d43[k];
				m2121_s2[k] <= g_s1.d21[k] * g_s1.d21[k];
			end
			g_s2    <= g_s1;
			degb_s2 <= degb_s1;
			dega_s2 <= dega_s1;
		end
		if (en3) begin
			d1343_s3 <= DOTW'(m1343_s2[0]) + DOTW'(m1343_s2[1]) + DOTW'(m1343_s2[2]);
			d4321_s3 <= DOTW'(m4321_s2[0]) + DOTW'(m4321_s2[1]) + DOTW'(m4321_s2[2]);
			d1321_s3 <= DOTW'(m1321_s2[0]) + DOTW'(m1321_s2[1]) + DOTW'(m1321_s2[2]);
			d4343_s3 <= DOTW'(m4343_s2[0]) + DOTW'(m4343_s2[1]) + DOTW'(m4343_s2[2]);
			d2121_s3 <= DOTW'(m2121_s2[0]) + DOTW'(m2121_s2[1]) + DOTW'(m2121_s2[2]);
			g_s3    <= g_s2;
			degb_s3 <= degb_s2;
			dega_s3 <= dega_s2;
		end
		if (en4) begin
			// 68x68 products as four partial products
			for (int k = 0; k < 4; k++) begin
				hh_s4[k] <= $signed(opa[k][DOTW-1:HW]) * $signed(opb[k][DOTW-1:HW]);
				hl_s4[k] <= $signed(opa[k][DOTW-1:HW]) * $signed({1'b0, opb[k][HW-1:0]});
				lh_s4[k] <= $signed({1'b0, opa[k][HW-1:0]}) * $signed(opb[k][DOTW-1:HW]);
				ll_s4[k] <= $signed({1'b0, opa[k][HW-1:0]}) *
					$signed({1'b0, opb[k][HW-1:0]});
			end
			d1343_s4 <= d1343_s3;
			d4321_s4 <= d4321_s3;
			d4343_s4 <= d4343_s3;
			g_s4     <= g_s3;
			degb_s4  <= degb_s3;
			dega_s4  <= dega_s3;
		end
		if (en5) begin
			for (int k = 0; k < 4; k++) begin
				pr_s5[k] <= (PRW'(hh_s4[k]) << (2 * HW)) +
					((PRW'(hl_s4[k]) + PRW'(lh_s4[k])) << HW) + PRW'(ll_s4[k]);
			end
			d1343_s5 <= d1343_s4;
			d4321_s5 <= d4321_s4;
			d4343_s5 <= d4343_s4;
			g_s5     <= g_s4;
			degb_s5  <= degb_s4;
			dega_s5  <= dega_s4;
		end
		if (en6) begin
			denom_s6 <= DENW'(pr_s5[0]) - DENW'(pr_s5[1]);
			numer_s6 <= DENW'(pr_s5[2]) - DENW'(pr_s5[3]);
			d1343_s6 <= d1343_s5;
			d4321_s6 <= d4321_s5;
			d4343_s6 <= d4343_s5;
			g_s6     <= g_s5;
			degb_s6  <= degb_s5;
			dega_s6  <= dega_s5;
		end
		if (en7) begin
			denom_s7 <= denom_s6;
			numer_s7 <= numer_s6;
			d1343_s7 <= d1343_s6;
			d4321_s7 <= d4321_s6;
			d4343_s7 <= d4343_s6;
			g_s7     <= g_s6;
			st_s7    <= st_c;
		end
	end

	always_comb begin
		par_c = (denom_s6 == '0) ||
			((denom_s6[DENW-1] ? DENW'(-denom_s6) : DENW'(denom_s6)) <
			(DENW'(eps_q) << (3 * FB)));
		if (degb_s6) begin
			st_c = ST_DEG_B;
		end else if (dega_s6) begin
			st_c = ST_DEG_A;
		end else if (par_c) begin
			st_c = ST_PAR;
		end else begin
			st_c = ST_OK;
		end
	end

	// mua divider
	side_a_t sa_in, sa_o;
	side_t   diva_side_in, diva_side_out;
	coord_t  mua_c;
	num_t    diva_num;

	always_comb begin
		sa_in.st    = st_s7;
		sa_in.g     = g_s7;
		sa_in.d1343 = d1343_s7;
		sa_in.d4321 = d4321_s7;
		sa_in.d4343 = d4343_s7;
	end

	assign diva_side_in = SIDE_W'(sa_in);
	assign diva_num     = NUMW'(numer_s7) <<< FB;
	assign sa_o         = side_a_t'(diva_side_out[$bits(side_a_t)-1:0]);

	cpl3d_div u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.in_ready  (diva_in_ready),
		.num       (diva_num),
		.den       (denom_s7),
		.side_in   (diva_side_in),
		.out_valid (diva_valid),
		.out_ready (en8),
		.quo       (mua_c),
		.side_out  (diva_side_out)
	);

	// stages 8 and 9: mub numerator, near point on A
	logic signed [HW+CW-1:0] mh_s8;
	logic signed [HW+CW:0]   ml_s8;
	nprod_t  na_s8 [3];
	dot_t    d1343_s8, d4343_s8, d4343_s9;
	coord_t  mua_s8, mua_s9;
	geom_t   g_s8, g_s9;
	status_t st_s8, st_s9;
	num_t    mb_s9;
	coord_t  near_a_s9 [3];

	always_ff @(posedge clk) begin
		if (en8) begin
			mh_s8 <= $signed(sa_o.d4321[DOTW-1:HW]) * mua_c;
			ml_s8 <= $signed({1'b0, sa_o.d4321[HW-1:0]}) * mua_c;
			for (int k = 0; k < 3; k++) begin
				na_s8[k] <= mua_c * sa_o.g.d21[k];
			end
			d1343_s8 <= sa_o.d1343;
			d4343_s8 <= sa_o.d4343;
			mua_s8   <= mua_c;
			g_s8     <= sa_o.g;
			st_s8    <= sa_o.st;
		end
		if (en9) begin
			mb_s9 <= (NUMW'(d1343_s8) <<< FB) + (NUMW'(mh_s8) <<< HW) + NUMW'(ml_s8);
			for (int k = 0; k < 3; k++) begin
				near_a_s9[k] <= sat_near(NEARW'(g_s8.p1[k]) + NEARW'(na_s8[k] >>> FB));
			end
			d4343_s9 <= d4343_s8;
			mua_s9   <= mua_s8;
			g_s9     <= g_s8;
			st_s9    <= st_s8;
		end
	end

	// mub divider
	side_b_t sb_in, sb_o;
	side_t   divb_side_in, divb_side_out;
	coord_t  mub_c;

	always_comb begin
		sb_in.st  = st_s9;
		sb_in.g   = g_s9;
		sb_in.mua = mua_s9;
		for (int k = 0; k < 3; k++) begin
			sb_in.near_a[k] = near_a_s9[k];
		end
	end

	assign divb_side_in = SIDE_W'(sb_in);
	assign sb_o         = side_b_t'(divb_side_out[$bits(side_b_t)-1:0]);

	cpl3d_div u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.in_ready  (divb_in_ready),
		.num       (mb_s9),
		.den       (DENW'(d4343_s9)),
		.side_in   (divb_side_in),
		.out_valid (divb_valid),
		.out_ready (en10),
		.quo       (mub_c),
		.side_out  (divb_side_out)
	);

	// stages 10 and 11: near point on B, output register
	nprod_t  nb_s10 [3];
	coord_t  mub_s10;
	side_b_t sb_s10;
	status_t st_s11;
	coord_t  near_a_s11 [3], near_b_s11 [3];
	coord_t  mua_s11, mub_s11;
	logic    ok_c;

	assign ok_c = sb_s10.st == ST_OK;

	always_ff @(posedge clk) begin
		if (en10) begin
			for (int k = 0; k < 3; k++) begin
				nb_s10[k] <= mub_c * sb_o.g.d43[k];
			end
			mub_s10 <= mub_c;
			sb_s10  <= sb_o;
		end
		if (en11) begin
			st_s11  <= sb_s10.st;
			mua_s11 <= ok_c ? sb_s10.mua : '0;
			mub_s11 <= ok_c ? mub_s10 : '0;
			for (int k = 0; k < 3; k++) begin
				near_a_s11[k] <= ok_c ? sb_s10.near_a[k] : '0;
				near_b_s11[k] <= ok_c ?
					sat_near(NEARW'(sb_s10.g.p3[k]) + NEARW'(nb_s10[k] >>> FB)) : '0;
			end
		end
	end

	assign out_ch.valid    = v_s11;
	assign out_ch.status   = st_s11;
	assign out_ch.near_a_x = near_a_s11[0];
	assign out_ch.near_a_y = near_a_s11[1];
	assign out_ch.near_a_z = near_a_s11[2];
	assign out_ch.near_b_x = near_b_s11[0];
	assign out_ch.near_b_y = near_b_s11[1];
	assign out_ch.near_b_z = near_b_s11[2];
	assign out_ch.param_a  = mua_s11;
	assign out_ch.param_b  = mub_s11;

endmodule
`default_nettype wire

// ----- verif/cpl3d_checker.sv -----
`timescale 1ns / 1ps
module cpl3d_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  cpl3d_pkg::eps_t     cfg_wr_data,
	cpl3d_in_if                 in_ch,
	cpl3d_out_if                out_ch,
	output int                  n_errors,
	output int                  n_pending,
	output int                  n_checked,
	output int                  n_by_status [4]
);
	import cpl3d_pkg::*;

	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		status_t st;
		coord_t [7:0] v;
	} solution_t;

	solution_t solutions_due[$];
	eps_t eps;

	function automatic wide_t mag(input wide_t x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic coord_t clamp_coord(input wide_t x);
		wide_t hi, lo;
		hi = CMAX;
		lo = CMIN;
		if (x > hi) return CMAX;
		if (x < lo) return CMIN;
		return x[CW-1:0];
	endfunction

	function automatic bit all_below(input wide_t d [3], input wide_t e);
		return mag(d[0]) < e && mag(d[1]) < e && mag(d[2]) < e;
	endfunction

	function automatic wide_t dot(input wide_t x [3], input wide_t y [3]);
		return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
	endfunction

	function automatic solution_t solve_pair(input coord_t c [12], input eps_t th);
		wide_t p [12];
		wide_t d13 [3], d43 [3], d21 [3];
		wide_t e, d1343, d4321, d1321, d4343, d2121, denom, numer, mua_w, mub_w;
		solution_t r;
		r = '0;
		e = {240'd0, th};
		for (int k = 0; k < 12; k++) p[k] = c[k];
		for (int k = 0; k < 3; k++) begin
			d13[k] = p[k] - p[6+k];
			d43[k] = p[9+k] - p[6+k];
			d21[k] = p[3+k] - p[k];
		end
		if (all_below(d43, e)) begin
			r.st = ST_DEG_B;
			return r;
		end
		if (all_below(d21, e)) begin
			r.st = ST_DEG_A;
			return r;
		end
		d1343 = dot(d13, d43);
		d4321 = dot(d43, d21);
		d1321 = dot(d13, d21);
		d4343 = dot(d43, d43);
		d2121 = dot(d21, d21);
		denom = d2121 * d4343 - d4321 * d4321;
		if (denom == 0 || mag(denom) < (e <<< (3 * FB))) begin
			r.st = ST_PAR;
			return r;
		end
		numer = d1343 * d4321 - d1321 * d4343;
		r.st = ST_OK;
		r.v[6] = clamp_coord((numer <<< FB) / denom);
		mua_w = r.v[6];
		r.v[7] = clamp_coord(((d1343 <<< FB) + d4321 * mua_w) / d4343);
		mub_w = r.v[7];
		for (int k = 0; k < 3; k++) begin
			r.v[k] = clamp_coord(p[k] + ((mua_w * d21[k]) >>> FB));
			r.v[3+k] = clamp_coord(p[6+k] + ((mub_w * d43[k]) >>> FB));
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		n_errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		coord_t c [12];
		solution_t got, want;
		if (!arst_n) begin
			eps <= EPS_RST;
			solutions_due.delete();
			n_errors = 0;
			n_checked = 0;
			n_pending <= 0;
			for (int k = 0; k < 4; k++) n_by_status[k] = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				c = '{in_ch.a_start_x, in_ch.a_start_y, in_ch.a_start_z,
					in_ch.a_end_x, in_ch.a_end_y, in_ch.a_end_z,
					in_ch.b_start_x, in_ch.b_start_y, in_ch.b_start_z,
					in_ch.b_end_x, in_ch.b_end_y, in_ch.b_end_z};
				solutions_due.push_back(solve_pair(c, eps));
			end
			if (out_ch.valid && out_ch.ready) begin
				got.st = out_ch.status;
				got.v = {out_ch.param_b, out_ch.param_a, out_ch.near_b_z, out_ch.near_b_y,
					out_ch.near_b_x, out_ch.near_a_z, out_ch.near_a_y, out_ch.near_a_x};
				if (solutions_due.size() == 0) begin
					report_mismatch("unexpected transfer", got.st, 0);
				end else begin
					want = solutions_due.pop_front();
					n_checked++;
					n_by_status[want.st]++;
					if (got.st !== want.st)
						report_mismatch("status", got.st, want.st);
					for (int k = 0; k < 8; k++)
						if (got.v[k] !== want.v[k])
							report_mismatch($sformatf("field %0d", k), got.v[k], want.v[k]);
				end
			end
			if (cfg_wr_en) eps <= cfg_wr_data;
			n_pending <= solutions_due.size();
		end
	end

endmodule

// ----- verif/tb_closest_points_two_lines_3d_top.sv -----
`timescale 1ns / 1ps
module tb_closest_points_two_lines_3d_top;
	import cpl3d_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	eps_t cfg_wr_data;
	eps_t cur_eps;
	logic hold_off;
	int n_errors, n_pending, n_checked;
	int n_by_status [4];
	int n_sent;
	int burst_left;
	bit gaps_on;
	int stall_mode;
	int mode_left;

	cpl3d_in_if in_ch ();
	cpl3d_out_if out_ch ();

	closest_points_two_lines_3d_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	cpl3d_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.n_errors    (n_errors),
		.n_pending   (n_pending),
		.n_checked   (n_checked),
		.n_by_status (n_by_status)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("timeout");
		$display("[closest_points_two_lines_3d_top] ERROR");
		$finish;
	end

	// long output hold-off while the sender keeps offering transfers
	initial begin
		hold_off = 1'b0;
		wait (n_sent > 400);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (500) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_mode <= 0;
			mode_left <= 150;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(50, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			if (hold_off)
				out_ch.ready <= 1'b0;
			else case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				2: out_ch.ready <= ($urandom_range(0, 1) != 0);
				default: out_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic send_pair(input coord_t c [12]);
		in_ch.valid <= 1'b1;
		{in_ch.a_start_x, in_ch.a_start_y, in_ch.a_start_z} <= {c[0], c[1], c[2]};
		{in_ch.a_end_x, in_ch.a_end_y, in_ch.a_end_z} <= {c[3], c[4], c[5]};
		{in_ch.b_start_x, in_ch.b_start_y, in_ch.b_start_z} <= {c[6], c[7], c[8]};
		{in_ch.b_end_x, in_ch.b_end_y, in_ch.b_end_z} <= {c[9], c[10], c[11]};
		@(negedge clk);
		while (!in_ch.ready) @(negedge clk);
		@(posedge clk);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			if (gaps_on) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic drain_and_write(input eps_t v);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_eps = v;
	endtask

	function automatic coord_t any_coord();
		return $urandom;
	endfunction

	function automatic coord_t near_coord(input int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic coord_t edge_coord();
		case ($urandom_range(0, 5))
			0: return CMAX;
			1: return CMIN;
			2: return '0;
			3: return '1;
			4: return 32'sd1 <<< FB;
			default: return -(32'sd1 <<< FB);
		endcase
	endfunction

	task automatic random_pair(output coord_t c [12]);
		int kind, span, e, f;
		kind = $urandom_range(0, 99);
		span = 1 << $urandom_range(4, 24);
		e = cur_eps + 1;
		for (int k = 0; k < 12; k++) c[k] = near_coord(span);
		if (kind < 15) begin
			for (int k = 0; k < 12; k++) c[k] = any_coord();
		end else if (kind < 20) begin
			for (int k = 0; k < 12; k++) c[k] = edge_coord();
		end else if (kind < 27) begin
			for (int k = 0; k < 3; k++) c[9+k] = c[6+k] + near_coord(e);
		end else if (kind < 34) begin
			for (int k = 0; k < 3; k++) c[3+k] = c[k] + near_coord(e);
		end else if (kind < 44) begin
			f = $urandom_range(0, 1) ? 2 : -1;
			for (int k = 0; k < 3; k++) c[9+k] = c[6+k] + f * (c[3+k] - c[k]);
		end else if (kind < 52) begin
			for (int k = 0; k < 3; k++) c[9+k] = c[6+k] + (c[3+k] - c[k]) + near_coord(3);
		end else if (kind < 58) begin
			for (int k = 0; k < 3; k++) begin
				c[3+k] = c[k] + near_coord(2);
				c[9+k] = c[6+k] + near_coord(2);
			end
		end
	endtask

	task automatic directed_pair(input int n, output coord_t c [12]);
		coord_t one;
		one = 32'sd1 <<< FB;
		for (int k = 0; k < 12; k++) c[k] = '0;
		case (n)
			0: ;
			1: begin c[9] = one; end
			2: begin c[3] = one; c[10] = one; end
			3: begin c[3] = one; c[9] = one; c[7] = one; end
			4: begin c[3] = one; c[9] = -one; c[8] = one; end
			5: begin c[3] = one; c[10] = one; c[6] = -one; c[8] = one <<< 2; end
			6: begin for (int k = 0; k < 12; k++) c[k] = (k % 2) ? CMAX : CMIN; end
			7: begin for (int k = 0; k < 12; k++) c[k] = (k % 3) ? CMIN : CMAX; end
			8: begin c[3] = CMAX; c[10] = CMIN; c[0] = CMIN; c[8] = CMAX; end
			9: begin c[9] = 32'sd6; c[3] = one; end
			10: begin c[9] = 32'sd7; c[3] = 32'sd7; end
			11: begin c[9] = 32'sd7; c[3] = 32'sd6; c[4] = -32'sd6; end
			12: begin c[3] = one; c[9] = one; c[10] = 32'sd1; c[8] = CMAX; end
			13: begin c[3] = 32'sd1; c[9] = one; c[11] = one; c[1] = CMAX; end
			14: begin c[3] = 32'sd64; c[4] = 32'sd1; c[9] = 32'sd64; c[8] = CMAX; end
			15: begin c[0] = CMAX; c[3] = CMIN; c[6] = CMIN; c[10] = CMAX; end
			16: begin for (int k = 0; k < 12; k++) c[k] = '1; c[3] = '0; c[10] = '0; end
			17: begin c[3] = one; c[4] = one; c[9] = one; c[10] = one + 1; c[8] = CMAX; end
			default: begin for (int k = 0; k < 12; k++) c[k] = edge_coord(); end
		endcase
	endtask

	initial begin
		coord_t c [12];
		eps_t eps_plan [6];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		cur_eps = EPS_RST;
		in_ch.valid = 1'b0;
		{in_ch.a_start_x, in_ch.a_start_y, in_ch.a_start_z} = '0;
		{in_ch.a_end_x, in_ch.a_end_y, in_ch.a_end_z} = '0;
		{in_ch.b_start_x, in_ch.b_start_y, in_ch.b_start_z} = '0;
		{in_ch.b_end_x, in_ch.b_end_y, in_ch.b_end_z} = '0;
		n_sent = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < 22; n++) begin
			directed_pair(n, c);
			send_pair(c);
		end
		drain_and_write(16'd0);
		for (int n = 0; n < 18; n++) begin
			directed_pair(n, c);
			send_pair(c);
		end

		eps_plan = '{16'd7, 16'hffff, 16'd1, eps_t'($urandom), 16'd0, 16'h8000};
		for (int ph = 0; ph < 6; ph++) begin
			drain_and_write(eps_plan[ph]);
			gaps_on = (ph != 2);
			for (int n = 0; n < 315; n++) begin
				random_pair(c);
				send_pair(c);
			end
		end

		in_ch.valid <= 1'b0;
		while (n_pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d line pairs sent over eight threshold settings, %0d results compared",
			n_sent, n_checked);
		$display("status mix: ok %0d, B degenerate %0d, A degenerate %0d, parallel %0d",
			n_by_status[0], n_by_status[1], n_by_status[2], n_by_status[3]);
		if (n_errors == 0)
			$display("[closest_points_two_lines_3d_top] OK");
		else
			$display("[closest_points_two_lines_3d_top] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/cpl3d_pkg.sv
hdl/cpl3d_in_if.sv
hdl/cpl3d_out_if.sv
hdl/cpl3d_div.sv
hdl/closest_points_two_lines_3d_top.sv
verif/cpl3d_checker.sv
verif/tb_closest_points_two_lines_3d_top.sv
